// ----- sv/tcra_pkg.sv -----
`timescale 1ns / 1ps

package tcra_pkg;

  // Receive window size in slots
  localparam int WINDOW_SLOTS = 64;
  localparam int SLOT_W       = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int CNT_W        = $clog2(WINDOW_SLOTS + 1);
  localparam int SEQ_W        = 32;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SEQ_W-1:0]  seq_t;

  // Operations of the shared adder
  typedef enum logic {
    OP_SUB,
    OP_INC
  } alu_op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_MARK,
    S_SCAN,
    S_EMIT
  } state_t;

  // Bitmap control from the sequencer
  typedef struct packed {
    logic  set_en;
    slot_t set_slot;
    logic  clr_en;
    slot_t clr_slot;
  } mark_ctl_t;

endpackage

// ----- sv/tcra_if.sv -----
`timescale 1ns / 1ps

interface tcra_in_if;
  import tcra_pkg::*;
  logic valid;
  logic ready;
  seq_t seq_number;

  modport source (output valid, output seq_number, input ready);
  modport sink   (input valid, input seq_number, output ready);
endinterface

interface tcra_out_if;
  import tcra_pkg::*;
  logic valid;
  logic ready;
  seq_t ack_number;
  logic send_ack;
  logic out_of_window;

  modport source (output valid, output ack_number, output send_ack,
                  output out_of_window, input ready);
  modport sink   (input valid, input ack_number, input send_ack,
                  input out_of_window, output ready);
endinterface

// ----- sv/tcra_alu.sv -----
`timescale 1ns / 1ps

module tcra_alu (
  input  tcra_pkg::alu_op_t op,
  input  tcra_pkg::seq_t    a,
  input  tcra_pkg::seq_t    b,
  output tcra_pkg::seq_t    y
);
  import tcra_pkg::*;

  seq_t opnd_b;
  logic cin;

  // Select second operand: negate for distance, carry-in of one for base advance
  always_comb begin
    case (op)
      OP_SUB: begin
        opnd_b = ~b;
        cin    = 1'b1;
      end
      OP_INC: begin
        opnd_b = '0;
        cin    = 1'b1;
      end
      default: begin
        opnd_b = '0;
        cin    = 1'b0;
      end
    endcase
  end

  assign y = a + opnd_b + seq_t'(cin);

endmodule

// ----- sv/tcra_marks.sv -----
`timescale 1ns / 1ps

module tcra_marks (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tcra_pkg::mark_ctl_t  ctl,
  input  tcra_pkg::slot_t      rd_slot,
  output logic                 rd_bit
);
  import tcra_pkg::*;

  logic [WINDOW_SLOTS-1:0] marks_r;
  logic [WINDOW_SLOTS-1:0] marks_nxt;

  // Set the arriving slot, clear the slot the base passes
  always_comb begin
    marks_nxt = marks_r;
    if (ctl.set_en) begin
      marks_nxt[ctl.set_slot] = 1'b1;
    end
    if (ctl.clr_en) begin
      marks_nxt[ctl.clr_slot] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marks_r <= '0;
    end else begin
      marks_r <= marks_nxt;
    end
  end

  assign rd_bit = marks_r[rd_slot];

endmodule

// ----- sv/tcp_receive_cumulative_ack_unit.sv -----
`timescale 1ns / 1ps

// Cumulative-ack receiver. Each word on in_ch is the sequence number of an
// arriving packet; each gives one word on out_ch with the new receive base
// as ack_number. Sequences are compared modulo 2^32. A packet below the base
// gives send_ack = 0; one beyond the window of WINDOW_SLOTS slots gives
// out_of_window = 1 and is not stored. An in-window packet is marked in a ring
// bitmap, after which the base advances over consecutive marked slots, one
// slot per cycle, through a single shared 32-bit adder. Per packet the base
// advances by 0 to WINDOW_SLOTS slots; a dropped or old packet skips the
// scan. in_ch is not ready while an item is being worked on; the result
// sits in an output register so the next word can be accepted while it
// waits to be taken.
module tcp_receive_cumulative_ack_unit (
  input  logic             clk,
  input  logic             rst_n,
  tcra_in_if.sink          in_ch,
  tcra_out_if.source       out_ch
);
  import tcra_pkg::*;

  state_t    state_r, state_nxt;
  seq_t      seq_r, seq_nxt;
  seq_t      dist_r, dist_nxt;
  seq_t      base_r, base_nxt;
  slot_t     base_slot_r, base_slot_nxt;
  cnt_t      cnt_r, cnt_nxt;
  logic      send_r, send_nxt;
  logic      oow_r, oow_nxt;
  logic      out_valid_r, out_valid_nxt;
  seq_t      out_ack_r, out_ack_nxt;
  logic      out_send_r, out_send_nxt;
  logic      out_oow_r, out_oow_nxt;

  alu_op_t   alu_op;
  seq_t      alu_y;
  mark_ctl_t mark_ctl;
  logic      mark_bit;
  logic [SLOT_W:0] slot_sum;
  slot_t     set_slot;

  tcra_alu u_alu (
    .op (alu_op),
    .a  ((state_r == S_DIFF) ? seq_r : base_r),
    .b  (base_r),
    .y  (alu_y)
  );

  tcra_marks u_marks (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mark_ctl),
    .rd_slot (base_slot_r),
    .rd_bit  (mark_bit)
  );

  // Ring slot of an in-window packet
  always_comb begin
    slot_sum = {1'b0, base_slot_r} + {1'b0, dist_r[SLOT_W-1:0]};
    if (slot_sum >= (SLOT_W+1)'(WINDOW_SLOTS)) begin
      slot_sum = slot_sum - (SLOT_W+1)'(WINDOW_SLOTS);
    end
    set_slot = slot_sum[SLOT_W-1:0];
  end

  assign in_ch.ready = (state_r == S_IDLE);

  // Sequencer: next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    seq_nxt       = seq_r;
    dist_nxt      = dist_r;
    base_nxt      = base_r;
    base_slot_nxt = base_slot_r;
    cnt_nxt       = cnt_r;
    send_nxt      = send_r;
    oow_nxt       = oow_r;
    out_valid_nxt = out_valid_r;
    out_ack_nxt   = out_ack_r;
    out_send_nxt  = out_send_r;
    out_oow_nxt   = out_oow_r;
    alu_op        = OP_INC;
    mark_ctl      = '0;

    // Drop the output word once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          seq_nxt   = in_ch.seq_number;
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        alu_op    = OP_SUB;
        dist_nxt  = alu_y;
        state_nxt = S_MARK;
      end
      S_MARK: begin
        cnt_nxt = '0;
        if (dist_r[SEQ_W-1]) begin
          send_nxt  = 1'b0;
          oow_nxt   = 1'b0;
          state_nxt = S_EMIT;
        end else if (dist_r >= SEQ_W'(WINDOW_SLOTS)) begin
          send_nxt  = 1'b1;
          oow_nxt   = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          send_nxt          = 1'b1;
          oow_nxt           = 1'b0;
          mark_ctl.set_en   = 1'b1;
          mark_ctl.set_slot = set_slot;
          state_nxt         = S_SCAN;
        end
      end
      S_SCAN: begin
        // Advance the base over one marked slot per cycle
        if (mark_bit && (cnt_r != CNT_W'(WINDOW_SLOTS))) begin
          alu_op            = OP_INC;
          base_nxt          = alu_y;
          mark_ctl.clr_en   = 1'b1;
          mark_ctl.clr_slot = base_slot_r;
          cnt_nxt           = cnt_r + CNT_W'(1);
          if (base_slot_r == SLOT_W'(WINDOW_SLOTS - 1)) begin
            base_slot_nxt = '0;
          end else begin
            base_slot_nxt = base_slot_r + SLOT_W'(1);
          end
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_ack_nxt   = base_r;
          out_send_nxt  = send_r;
          out_oow_nxt   = oow_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      base_slot_r <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      base_slot_r <= base_slot_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    seq_r      <= seq_nxt;
    dist_r     <= dist_nxt;
    send_r     <= send_nxt;
    oow_r      <= oow_nxt;
    out_ack_r  <= out_ack_nxt;
    out_send_r <= out_send_nxt;
    out_oow_r  <= out_oow_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.ack_number    = out_ack_r;
  assign out_ch.send_ack      = out_send_r;
  assign out_ch.out_of_window = out_oow_r;

  // Advance never passes the window size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(WINDOW_SLOTS))
    else $error("scan count beyond window");

  // Base and its ring slot move only during the scan
  a_base_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_SCAN) |=> $stable(base_r) && $stable(base_slot_r))
    else $error("base moved outside scan");

  // A dropped or old packet goes straight to the result
  a_drop_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARK) && (dist_r[SEQ_W-1] || (dist_r >= SEQ_W'(WINDOW_SLOTS)))
    |=> (state_r == S_EMIT))
    else $error("dropped packet did not go to emit");

  // An out-of-window result always carries an ack
  a_oow_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_send_r || !out_oow_r))
    else $error("out-of-window word without ack");

  // Each accepted word starts the distance step
  a_accept_diff: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == S_DIFF))
    else $error("accepted word did not start");

endmodule
